// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define R2FFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error(msg);

// Checked on every edge, reset included.
`define R2FFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
  else $error(msg);

`endif

// File: rtl/r2fft_pkg.sv
package r2fft_pkg;

  localparam int LOG2_MAX_POINTS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int WB                  = 27;   // work word width
  localparam int TW_BITS             = 16;   // twiddle width, Q1.15
  localparam int OUT_TDATA_W         = ((2 * WB + 7) / 8) * 8;

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [0:0] {REG_LOG2_POINTS = 1'b0, REG_INVERSE = 1'b1} cfg_reg_t;
  typedef enum logic [0:0] {OP_LOAD = 1'b0, OP_READ = 1'b1} op_t;

  // product schedule of the shared multiplier
  typedef enum logic [2:0] {BS_RR, BS_II, BS_RI, BS_IR, BS_ACC} bf_step_t;

  typedef struct packed {
    logic     en;
    bf_step_t step;
  } bf_ctl_t;

  function automatic logic signed [WB-1:0] sat_w(input logic signed [WB+2:0] v);
    logic signed [WB+2:0] hi;
    logic signed [WB+2:0] lo;
    hi = (WB+3)'((64'sd1 <<< (WB - 1)) - 1);
    lo = -(WB+3)'(64'sd1 <<< (WB - 1));
    if (v > hi) return hi[WB-1:0];
    if (v < lo) return lo[WB-1:0];
    return v[WB-1:0];
  endfunction

  function automatic logic signed [WB-1:0] neg_sat(input logic signed [WB-1:0] x);
    logic signed [WB+2:0] t;
    t = -{{3{x[WB-1]}}, x};
    return sat_w(t);
  endfunction

  function automatic logic [15:0] q15_of(input longint unsigned q30, input logic neg);
    longint unsigned m;
    m = (q30 + (64'd1 << 14)) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    return neg ? 16'(-m) : 16'(m);
  endfunction

  // {-sin, cos} of 2*pi*k/2^lg, Taylor series in Q30
  function automatic logic [31:0] tw_entry(input int unsigned k, input int unsigned lg);
    longint unsigned phase, quad, f, g, x, x2, t, s, c, sv, cv;
    logic            swp;
    logic [15:0]     cr, sr;
    phase = longint'(k) << (32 - lg);
    quad  = (phase >> 30) & 64'd3;
    f     = phase & (Q30_ONE - 64'd1);
    swp   = f > (64'd1 << 29);
    g     = swp ? Q30_ONE - f : f;
    x     = (g * TWO_PI_Q30 + (64'd1 << 31)) >> 32;
    x2    = (x * x) >> 30;
    t = Q30_ONE - x2 / 72;
    t = Q30_ONE - ((x2 * t) >> 30) / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = Q30_ONE - x2 / 90;
    t = Q30_ONE - ((x2 * t) >> 30) / 56;
    t = Q30_ONE - ((x2 * t) >> 30) / 30;
    t = Q30_ONE - ((x2 * t) >> 30) / 12;
    c = Q30_ONE - ((x2 * t) >> 30) / 2;
    sv = swp ? c : s;
    cv = swp ? s : c;
    case (quad)
      64'd0:   begin cr = q15_of(cv, 1'b0); sr = q15_of(sv, 1'b1); end
      64'd1:   begin cr = q15_of(sv, 1'b1); sr = q15_of(cv, 1'b1); end
      64'd2:   begin cr = q15_of(cv, 1'b1); sr = q15_of(sv, 1'b0); end
      default: begin cr = q15_of(sv, 1'b0); sr = q15_of(cv, 1'b0); end
    endcase
    return {sr, cr};
  endfunction

endpackage

// File: rtl/r2fft_twrom.sv
module r2fft_twrom #(
  parameter int LOG2_MAX_POINTS = r2fft_pkg::LOG2_MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic [LOG2_MAX_POINTS-2:0]            addr,
  output logic signed [r2fft_pkg::TW_BITS-1:0]  wr,
  output logic signed [r2fft_pkg::TW_BITS-1:0]  wi
);
  import r2fft_pkg::*;

  localparam int TW_N = 2 ** (LOG2_MAX_POINTS - 1);

  typedef logic [2*TW_BITS-1:0] rom_t [TW_N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TW_N; k++) r[k] = tw_entry(k, LOG2_MAX_POINTS);
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [2*TW_BITS-1:0] rd_r;

  always_ff @(posedge clk) begin
    rd_r <= ROM[addr];
  end

  assign wr = rd_r[TW_BITS-1:0];
  assign wi = rd_r[2*TW_BITS-1:TW_BITS];

endmodule

// File: rtl/r2fft_bfly.sv
// One multiplier, one accumulator; four products per butterfly.
module r2fft_bfly (
  input  logic                                  clk,
  input  r2fft_pkg::bf_ctl_t                    ctl,
  input  logic signed [r2fft_pkg::WB-1:0]       ar,
  input  logic signed [r2fft_pkg::WB-1:0]       ai,
  input  logic signed [r2fft_pkg::WB-1:0]       br,
  input  logic signed [r2fft_pkg::WB-1:0]       bi,
  input  logic signed [r2fft_pkg::TW_BITS-1:0]  wr,
  input  logic signed [r2fft_pkg::TW_BITS-1:0]  wi,
  output logic signed [r2fft_pkg::WB-1:0]       sum_re,
  output logic signed [r2fft_pkg::WB-1:0]       sum_im,
  output logic signed [r2fft_pkg::WB-1:0]       dif_re,
  output logic signed [r2fft_pkg::WB-1:0]       dif_im
);
  import r2fft_pkg::*;

  localparam int PW = WB + TW_BITS;

  logic signed [PW-1:0]  prod_r;
  logic signed [PW:0]    acc_r;
  logic signed [WB+1:0]  tr_r;
  logic signed [WB-1:0]  opx;
  logic signed [TW_BITS-1:0] opy;
  logic signed [PW:0]    rnd;
  logic signed [WB+1:0]  ti;

  always_comb begin
    opx = (ctl.step == BS_RR || ctl.step == BS_RI) ? br : bi;
    opy = (ctl.step == BS_RR || ctl.step == BS_IR) ? wr : wi;
    rnd = (acc_r + (PW+1)'(1 << 14)) >>> 15;   // round half up
    ti  = rnd[WB+1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= opx * opy;
      case (ctl.step)
        BS_II:   acc_r <= {prod_r[PW-1], prod_r};
        BS_RI:   acc_r <= acc_r - {prod_r[PW-1], prod_r};
        BS_IR:   begin
          tr_r  <= rnd[WB+1:0];
          acc_r <= {prod_r[PW-1], prod_r};
        end
        BS_ACC:  acc_r <= acc_r + {prod_r[PW-1], prod_r};
        default: acc_r <= acc_r;
      endcase
    end
  end

  always_comb begin
    sum_re = sat_w({{3{ar[WB-1]}}, ar} + {tr_r[WB+1], tr_r});
    sum_im = sat_w({{3{ai[WB-1]}}, ai} + {ti[WB+1], ti});
    dif_re = sat_w({{3{ar[WB-1]}}, ar} - {tr_r[WB+1], tr_r});
    dif_im = sat_w({{3{ai[WB-1]}}, ai} - {ti[WB+1], ti});
  end

endmodule

// File: rtl/radix2_fft_ifft.sv
// In-place radix-2 DIT FFT/IFFT over N = 2^log2_points points (log2_points 0 acts as 1,
// above LOG2_MAX_POINTS acts as the max). A load word (tuser 0) is written as it is taken;
// a read word (tuser 1) gives its result through the memory read register and the result
// register, and the input stays blocked until that result is taken. The load that
// completes a block runs the transform with in_tready low: a reorder pass that swaps each
// index pair (a skipped index is only checked), then (N/2)*log2(N) butterflies, plus a 1/N
// scaling pass in inverse mode. The pace is set by the simple dual-port work memory (one
// read and one write per cycle) and the one shared multiplier, which forms the four partial
// products of each butterfly in turn.
module radix2_fft_ifft #(
  parameter int LOG2_MAX_POINTS = r2fft_pkg::LOG2_MAX_POINTS_DEF,
  parameter int SAMPLE_BITS     = r2fft_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W = ((2 * SAMPLE_BITS + LOG2_MAX_POINTS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [3:0]                          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_W-1:0]                     in_tdata,  // sample_real, sample_imag, bin_index
  input  logic [0:0]                          in_tuser,  // op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [r2fft_pkg::OUT_TDATA_W-1:0]   out_tdata, // bin_real, bin_imag
  output logic [0:0]                          out_tuser  // index_out_of_range
);
  import r2fft_pkg::*;

  localparam int LMAX = LOG2_MAX_POINTS;
  localparam int NPTS = 1 << LMAX;
  localparam int LW   = $clog2(LMAX + 1);
  localparam int KW   = LMAX - 1;
  localparam int SB   = SAMPLE_BITS;
  localparam int DW   = 2 * WB;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_SW0, S_SW1, S_SW2, S_SW3,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8, S_B9,
    S_SC0, S_SC1
  } state_t;

  state_t           st_r, st_nxt;
  logic [3:0]       log2_points_r;
  logic             inverse_r;
  logic [LMAX:0]    cnt_r, cnt_nxt;
  logic [LMAX-1:0]  i_r, i_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [LW-1:0]    m_r, m_nxt;
  logic [DW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic             rd_oor_r, rd_oor_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WB-1:0]    out_re_r, out_re_nxt, out_im_r, out_im_nxt;
  logic             out_oor_r, out_oor_nxt;

  logic [DW-1:0]    mem [NPTS];
  logic [DW-1:0]    rdata_r;
  logic             mem_we;
  logic [LMAX-1:0]  mem_waddr, mem_raddr;
  logic [DW-1:0]    mem_wdata;

  logic [LW-1:0]    l_eff;
  logic [LMAX:0]    n_pts;
  logic [LMAX-1:0]  rev, j_idx, k_ext, lmask, a_idx, b_idx, i_last;
  logic [KW-1:0]    tw_idx, k_last;
  logic [LMAX:0]    cur;
  logic             accept;
  logic [SB-1:0]    smp_re, smp_im;
  logic [LMAX-1:0]  bin_idx;

  bf_ctl_t                     bf_ctl;
  logic signed [TW_BITS-1:0]   wr, wi;
  logic signed [WB-1:0]        sum_re, sum_im, dif_re, dif_im;

  function automatic logic [DW-1:0] cj(input logic [DW-1:0] x, input logic inv);
    return inv ? {neg_sat(x[DW-1:WB]), x[WB-1:0]} : x;
  endfunction

  function automatic logic [WB-1:0] scl(input logic [WB-1:0] x, input logic [LW-1:0] sh);
    logic signed [WB:0] t;
    t = $signed({x[WB-1], x}) + $signed((WB+1)'(1) << (sh - LW'(1)));
    t = t >>> sh;
    return t[WB-1:0];
  endfunction

  r2fft_twrom #(.LOG2_MAX_POINTS(LOG2_MAX_POINTS)) u_twrom (
    .clk  (clk),
    .addr (tw_idx),
    .wr   (wr),
    .wi   (wi)
  );

  r2fft_bfly u_bfly (
    .clk    (clk),
    .ctl    (bf_ctl),
    .ar     (a_r[WB-1:0]),
    .ai     (a_r[DW-1:WB]),
    .br     (b_r[WB-1:0]),
    .bi     (b_r[DW-1:WB]),
    .wr     (wr),
    .wi     (wi),
    .sum_re (sum_re),
    .sum_im (sum_im),
    .dif_re (dif_re),
    .dif_im (dif_im)
  );

  always_comb begin
    if (log2_points_r == 4'd0) l_eff = LW'(1);
    else if (32'(log2_points_r) > LMAX) l_eff = LW'(LMAX);
    else l_eff = LW'(log2_points_r);
    n_pts  = (LMAX+1)'(1) << l_eff;
    i_last = LMAX'(n_pts - (LMAX+1)'(1));
    k_last = KW'((n_pts >> 1) - (LMAX+1)'(1));
    for (int b = 0; b < LMAX; b++) rev[b] = i_r[LMAX-1-b];
    j_idx  = rev >> (LW'(LMAX) - l_eff);
    k_ext  = LMAX'(k_r);
    lmask  = (LMAX'(1) << (m_r - LW'(1))) - LMAX'(1);
    a_idx  = ((k_ext & ~lmask) << 1) | (k_ext & lmask);
    b_idx  = a_idx | (LMAX'(1) << (m_r - LW'(1)));
    tw_idx = KW'((k_ext & lmask) << (LW'(LMAX) - m_r));
    smp_re = in_tdata[SB-1:0];
    smp_im = in_tdata[2*SB-1:SB];
    bin_idx = in_tdata[2*SB+LMAX-1:2*SB];
    in_tready = (st_r == S_IDLE) && !out_valid_r;
    accept = in_tvalid && in_tready;
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rd_oor_nxt    = rd_oor_r;
    out_valid_nxt = out_valid_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_oor_nxt   = out_oor_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    bf_ctl        = '{en: 1'b0, step: BS_RR};
    cur           = (cnt_r >= n_pts) ? '0 : cnt_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(in_tuser[0]) == OP_READ) begin
            mem_raddr  = bin_idx;
            rd_oor_nxt = {1'b0, bin_idx} >= n_pts;
            st_nxt     = S_RD;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur[LMAX-1:0];
            mem_wdata = {{(WB-SB){smp_im[SB-1]}}, smp_im, {(WB-SB){smp_re[SB-1]}}, smp_re};
            cnt_nxt   = cur + (LMAX+1)'(1);
            if (cnt_nxt >= n_pts) begin
              cnt_nxt = '0;
              i_nxt   = '0;
              st_nxt  = S_SW0;
            end
          end
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_oor_nxt   = rd_oor_r;
        out_re_nxt    = rd_oor_r ? '0 : rdata_r[WB-1:0];
        out_im_nxt    = rd_oor_r ? '0 : rdata_r[DW-1:WB];
        st_nxt        = S_IDLE;
      end
      // bit-reversal reorder, conjugating on the way in inverse mode
      S_SW0: begin
        if (i_r > j_idx) begin
          if (i_r == i_last) begin
            m_nxt  = LW'(1);
            k_nxt  = '0;
            st_nxt = S_B0;
          end else begin
            i_nxt = i_r + LMAX'(1);
          end
        end else begin
          mem_raddr = i_r;
          st_nxt    = S_SW1;
        end
      end
      S_SW1: begin
        mem_raddr = j_idx;
        a_nxt     = rdata_r;
        st_nxt    = S_SW2;
      end
      S_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cj(rdata_r, inverse_r);
        st_nxt    = S_SW3;
      end
      S_SW3: begin
        mem_we    = 1'b1;
        mem_waddr = j_idx;
        mem_wdata = cj(a_r, inverse_r);
        if (i_r == i_last) begin
          m_nxt  = LW'(1);
          k_nxt  = '0;
          st_nxt = S_B0;
        end else begin
          i_nxt  = i_r + LMAX'(1);
          st_nxt = S_SW0;
        end
      end
      S_B0: begin
        mem_raddr = a_idx;
        st_nxt    = S_B1;
      end
      S_B1: begin
        mem_raddr = b_idx;
        a_nxt     = rdata_r;
        st_nxt    = S_B2;
      end
      S_B2: begin
        b_nxt  = rdata_r;
        st_nxt = S_B3;
      end
      S_B3: begin bf_ctl = '{en: 1'b1, step: BS_RR};  st_nxt = S_B4; end
      S_B4: begin bf_ctl = '{en: 1'b1, step: BS_II};  st_nxt = S_B5; end
      S_B5: begin bf_ctl = '{en: 1'b1, step: BS_RI};  st_nxt = S_B6; end
      S_B6: begin bf_ctl = '{en: 1'b1, step: BS_IR};  st_nxt = S_B7; end
      S_B7: begin bf_ctl = '{en: 1'b1, step: BS_ACC}; st_nxt = S_B8; end
      S_B8: begin
        mem_we    = 1'b1;
        mem_waddr = b_idx;
        mem_wdata = {dif_im, dif_re};
        st_nxt    = S_B9;
      end
      S_B9: begin
        mem_we    = 1'b1;
        mem_waddr = a_idx;
        mem_wdata = {sum_im, sum_re};
        if (k_r == k_last) begin
          k_nxt = '0;
          if (m_r == l_eff) begin
            i_nxt  = '0;
            st_nxt = inverse_r ? S_SC0 : S_IDLE;
          end else begin
            m_nxt  = m_r + LW'(1);
            st_nxt = S_B0;
          end
        end else begin
          k_nxt  = k_r + KW'(1);
          st_nxt = S_B0;
        end
      end
      // inverse: conjugate back and scale by 1/N
      S_SC0: begin
        mem_raddr = i_r;
        st_nxt    = S_SC1;
      end
      S_SC1: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = {scl(neg_sat(rdata_r[DW-1:WB]), l_eff), scl(rdata_r[WB-1:0], l_eff)};
        i_nxt     = i_r + LMAX'(1);
        st_nxt    = (i_r == i_last) ? S_IDLE : S_SC0;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      log2_points_r <= 4'd10;
      inverse_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_LOG2_POINTS: log2_points_r <= cfg_wdata;
          REG_INVERSE:     inverse_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    m_r       <= m_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    rd_oor_r  <= rd_oor_nxt;
    out_re_r  <= out_re_nxt;
    out_im_r  <= out_im_nxt;
    out_oor_r <= out_oor_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-DW)'(0), out_im_r, out_re_r};
  assign out_tuser  = out_oor_r;

endmodule

// File: rtl/r2fft_chk.sv
`include "assert_macros.svh"

module r2fft_chk #(
  parameter int IN_W  = 48,
  parameter int OUT_W = 56
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_W-1:0]   in_tdata,
  input logic [0:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic [0:0]        out_tuser
);

  `R2FFT_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid, "result word survived reset")
  `R2FFT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "stalled result word dropped")
  `R2FFT_ASSERT(a_oor_zero, out_tvalid && out_tuser[0] |-> out_tdata == '0, "out-of-range bin carries data")
  `R2FFT_ASSERT(a_res_from_read, $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser[0], 2), "result word without a read word")
  `R2FFT_ASSERT(a_busy_on_result, out_tvalid |-> !in_tready, "input taken while a result waits")

endmodule

bind radix2_fft_ifft r2fft_chk #(.IN_W(IN_W), .OUT_W(r2fft_pkg::OUT_TDATA_W)) u_r2fft_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import r2fft_pkg::*;

  localparam int LMAX = 10;
  localparam int NMAX = 1 << LMAX;
  localparam int TWN  = NMAX / 2;
  localparam int IN_W = ((2 * 16 + LMAX + 7) / 8) * 8;

  typedef struct {
    logic [WB-1:0] re;
    logic [WB-1:0] im;
    logic          oor;
  } bin_word_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [0:0]             cfg_addr;
  logic [3:0]             cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  radix2_fft_ifft u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // shadow of the block
  longint    fft_re[NMAX];
  longint    fft_im[NMAX];
  bit        written[NMAX];
  int        samples_in;
  int        log2_reg;
  bit        inv_reg;
  longint    tw_cos[TWN];
  longint    tw_nsin[TWN];

  bin_word_t pending_bins[$];
  int        errors;
  int        words_sent;
  int        snd_idle_pct;
  int        rx_idle_pct;
  int        rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sat27(longint v);
    if (v > 64'sd67108863) return 64'sd67108863;
    if (v < -64'sd67108864) return -64'sd67108864;
    return v;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint to_q15(longint unsigned q30, bit neg);
    longint unsigned m;
    m = (q30 + (64'd1 << 14)) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void build_twiddles();
    longint unsigned ph, quad, f, g, x, x2, t, s, c, sv, cv;
    bit swp;
    for (int k = 0; k < TWN; k++) begin
      ph   = longint'(k) << (32 - LMAX);
      quad = (ph >> 30) & 64'd3;
      f    = ph & (Q30_ONE - 64'd1);
      swp  = f > (64'd1 << 29);
      g    = swp ? Q30_ONE - f : f;
      x    = (g * TWO_PI_Q30 + (64'd1 << 31)) >> 32;
      x2   = (x * x) >> 30;
      t = Q30_ONE - x2 / 72;
      t = Q30_ONE - ((x2 * t) >> 30) / 42;
      t = Q30_ONE - ((x2 * t) >> 30) / 20;
      t = Q30_ONE - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      t = Q30_ONE - x2 / 90;
      t = Q30_ONE - ((x2 * t) >> 30) / 56;
      t = Q30_ONE - ((x2 * t) >> 30) / 30;
      t = Q30_ONE - ((x2 * t) >> 30) / 12;
      c = Q30_ONE - ((x2 * t) >> 30) / 2;
      sv = swp ? c : s;
      cv = swp ? s : c;
      case (quad)
        64'd0: begin tw_cos[k] = to_q15(cv, 0); tw_nsin[k] = to_q15(sv, 1); end
        64'd1: begin tw_cos[k] = to_q15(sv, 1); tw_nsin[k] = to_q15(cv, 1); end
        64'd2: begin tw_cos[k] = to_q15(cv, 1); tw_nsin[k] = to_q15(sv, 0); end
        default: begin tw_cos[k] = to_q15(sv, 0); tw_nsin[k] = to_q15(cv, 0); end
      endcase
    end
  endfunction

  function automatic int eff_log2();
    if (log2_reg < 1) return 1;
    if (log2_reg > LMAX) return LMAX;
    return log2_reg;
  endfunction

  function automatic void run_transform();
    int L, n, j, half, span, r;
    longint wr, wi, br, bi, tr, ti, ar, ai, tmp;
    L = eff_log2();
    n = 1 << L;
    if (inv_reg) for (int i = 0; i < n; i++) fft_im[i] = sat27(-fft_im[i]);
    for (int i = 0; i < n; i++) begin
      j = 0;
      for (int b = 0; b < L; b++) j |= ((i >> b) & 1) << (L - 1 - b);
      if (i < j) begin
        tmp = fft_re[i]; fft_re[i] = fft_re[j]; fft_re[j] = tmp;
        tmp = fft_im[i]; fft_im[i] = fft_im[j]; fft_im[j] = tmp;
      end
    end
    for (int m = 1; m <= L; m++) begin
      half = 1 << (m - 1);
      span = half << 1;
      for (int l = 0; l < half; l++) begin
        r  = ((l << (L - m)) << (LMAX - L)) & (TWN - 1);
        wr = tw_cos[r];
        wi = tw_nsin[r];
        for (int a = l; a < n; a += span) begin
          br = fft_re[a + half];
          bi = fft_im[a + half];
          tr = round_shr(br * wr - bi * wi, 15);
          ti = round_shr(br * wi + bi * wr, 15);
          ar = fft_re[a];
          ai = fft_im[a];
          fft_re[a + half] = sat27(ar - tr);
          fft_im[a + half] = sat27(ai - ti);
          fft_re[a] = sat27(ar + tr);
          fft_im[a] = sat27(ai + ti);
        end
      end
    end
    if (inv_reg) begin
      for (int i = 0; i < n; i++) begin
        fft_im[i] = sat27(-fft_im[i]);
        fft_re[i] = sat27(round_shr(fft_re[i], L));
        fft_im[i] = sat27(round_shr(fft_im[i], L));
      end
    end
    for (int i = 0; i < n; i++) written[i] = 1'b1;
  endfunction

  // expected effect of one accepted word
  function automatic void predict_word(op_t op, logic [15:0] sr, logic [15:0] si, int idx);
    int n;
    bin_word_t e;
    n = 1 << eff_log2();
    if (op == OP_LOAD) begin
      if (samples_in >= n) samples_in = 0;
      fft_re[samples_in] = longint'($signed(sr));
      fft_im[samples_in] = longint'($signed(si));
      written[samples_in] = 1'b1;
      samples_in++;
      if (samples_in >= n) begin
        run_transform();
        samples_in = 0;
      end
    end else begin
      if (idx >= n) begin
        e.re = '0; e.im = '0; e.oor = 1'b1;
      end else begin
        e.re = fft_re[idx][WB-1:0]; e.im = fft_im[idx][WB-1:0]; e.oor = 1'b0;
      end
      pending_bins.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    bin_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected bin word: %h oor %b", out_tdata, out_tuser);
      end else begin
        e = pending_bins.pop_front();
        if (out_tdata[WB-1:0] !== e.re || out_tdata[2*WB-1:WB] !== e.im
            || out_tuser[0] !== e.oor) begin
          errors++;
          if (errors <= 10)
            $display("bin mismatch: exp re %0d im %0d oor %b, got re %0d im %0d oor %b",
                     $signed(e.re), $signed(e.im), e.oor, $signed(out_tdata[WB-1:0]),
                     $signed(out_tdata[2*WB-1:WB]), out_tuser[0]);
        end
      end
    end
  end

  task automatic send_word(op_t op, logic [15:0] sr, logic [15:0] si, int idx);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, 10'(idx), si, sr};
    do @(posedge clk); while (!in_tready);
    predict_word(op, sr, si, idx);
    words_sent++;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic load(logic [15:0] sr, logic [15:0] si);
    send_word(OP_LOAD, sr, si, 0);
  endtask

  task automatic read_bin(int idx);
    send_word(OP_READ, 16'h0, 16'h0, idx);
  endtask

  // drains all results; every phase ends on a read, so no transform is still running
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= 4'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (r == REG_LOG2_POINTS) log2_reg = v & 15;
    else inv_reg = v & 1;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // a bin that is legal to read: out of range, or already written
  function automatic int pick_bin();
    int n, idx;
    n = 1 << eff_log2();
    if (n < NMAX && $urandom_range(4) == 0) return $urandom_range(NMAX - 1, n);
    idx = $urandom_range(n - 1);
    if (written[idx]) return idx;
    for (int i = 0; i < n; i++) if (written[i]) return i;
    return (n < NMAX) ? n : -1;
  endfunction

  task automatic load_block(int count);
    for (int i = 0; i < count; i++) begin
      load(rand_sample(), rand_sample());
      if ($urandom_range(19) == 0 && pick_bin() >= 0) read_bin(pick_bin());
    end
  endtask

  task automatic test_directed();
    snd_idle_pct = 0;
    rx_idle_pct  = 0;
    // length register 0 acts as a 2-point transform
    write_reg(REG_LOG2_POINTS, 0);
    write_reg(REG_INVERSE, 0);
    load(16'h7fff, 16'h8000);
    load(16'h8000, 16'h7fff);
    read_bin(0); read_bin(1); read_bin(2); read_bin(1023);
    wait_idle();
    write_reg(REG_LOG2_POINTS, 2);
    write_reg(REG_INVERSE, 1);
    load(16'h7fff, 16'h7fff); load(16'h8000, 16'h8000);
    load(16'hffff, 16'h0000); load(16'h0001, 16'hffff);
    for (int i = 0; i < 5; i++) read_bin(i);
    wait_idle();
    // shrink the length while a block is partly loaded: restart at sample 0
    write_reg(REG_LOG2_POINTS, 3);
    write_reg(REG_INVERSE, 0);
    repeat (5) load(rand_sample(), rand_sample());
    read_bin(0);
    wait_idle();
    write_reg(REG_LOG2_POINTS, 2);
    repeat (4) load(rand_sample(), rand_sample());
    read_bin(3); read_bin(4);
    wait_idle();
    // above the maximum acts as the maximum: two loads start no transform
    write_reg(REG_LOG2_POINTS, 15);
    load(16'h1234, 16'hedcb); load(16'h8000, 16'h7fff);
    read_bin(0); read_bin(1);
    wait_idle();
    write_reg(REG_LOG2_POINTS, 1);
    load(rand_sample(), rand_sample()); load(rand_sample(), rand_sample());
    read_bin(0);
    wait_idle();
  endtask

  task automatic test_full_length();
    snd_idle_pct = 26;
    rx_idle_pct  = 73;
    write_reg(REG_LOG2_POINTS, LMAX - 1);
    write_reg(REG_INVERSE, 1);
    load_block(NMAX / 2);
    read_bin(0); read_bin(NMAX / 2 - 1); read_bin(NMAX / 2);
    repeat (10) read_bin($urandom_range(NMAX / 2 - 1));
    wait_idle();
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    repeat (20) read_bin(pick_bin());
    wait_idle();
  endtask

  task automatic test_random(int snd_pct, int rx_pct, int words);
    int stop, n, lg;
    bit first;
    snd_idle_pct = snd_pct;
    rx_idle_pct  = rx_pct;
    stop = words_sent + words;
    first = 1'b1;
    while (words_sent < stop) begin
      if (first || $urandom_range(2) == 0) begin
        first = 1'b0;
        wait_idle();
        lg = ($urandom_range(9) == 0) ? $urandom_range(7, 0) : $urandom_range(5, 1);
        write_reg(REG_LOG2_POINTS, lg);
        write_reg(REG_INVERSE, $urandom_range(1));
      end
      n = 1 << eff_log2();
      load_block(($urandom_range(7) == 0) ? $urandom_range(n, 1) : n);
      repeat ($urandom_range(8, 1)) if (pick_bin() >= 0) read_bin(pick_bin());
    end
    wait_idle();
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_LOG2_POINTS;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_LOAD;
    errors     = 0;
    words_sent = 0;
    rx_hold    = 0;
    samples_in = 0;
    log2_reg   = 10;
    inv_reg    = 0;
    snd_idle_pct = 0;
    rx_idle_pct  = 0;
    for (int i = 0; i < NMAX; i++) begin
      fft_re[i] = 0; fft_im[i] = 0; written[i] = 0;
    end
    build_twiddles();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_length();
    test_random(26, 73, 70);
    test_backpressure();
    test_random(73, 26, 70);
    test_random(0, 0, 70);

    repeat (20) @(posedge clk);
    if (errors == 0 && pending_bins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
